@@ rtl/cmd3d_pkg.sv @@
// cmd3d_pkg: shared types and constants of the cloud-in-cell mass deposition block
// no dependencies; compiled before every other file of the block
`default_nettype none

package cmd3d_pkg;

    // action codes carried on the input tuser
    typedef enum logic [1:0] {
        ACT_DEPOSIT = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // field widths
    localparam int POS_W   = 32;
    localparam int MASS_W  = 32;
    localparam int INV_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int CELL_W  = 24;
    localparam int ACC_W   = 48;
    localparam int NIDX_W  = 15;
    localparam int WGT_W   = FRAC_W + 1;

    // widths of the shared multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // wide enough for any node count the mesh can have (256^3)
    localparam int IDXW_W  = 25;

    // 1.0 in Q1.16 and in Q8.24
    localparam logic [WGT_W-1:0] ONE_Q16       = 17'h10000;
    localparam logic [INV_W-1:0] INV_CELL_INIT = 32'h0100_0000;

endpackage

`default_nettype wire

@@ rtl/cmd3d_ram.sv @@
// cmd3d_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module cmd3d_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read, read returns the old value on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/cic_mass_deposit_3d.sv @@
// cic_mass_deposit_3d: cloud-in-cell mass deposition onto a cubic mesh of accumulators
// depends on cmd3d_pkg (types, constants) and cmd3d_ram (mesh store)
//
// Usage
//   Slave stream s_*: one transaction per action. s_tuser holds the action
//   (deposit, clear, read); s_tdata holds pos_x, pos_y, pos_z, particle_mass
//   and node_index. Master stream m_*: exactly one result transaction per
//   action, node_mass on m_tdata and the saturation flag on m_tuser.
//   inv_cell_size is written through cfg_we / cfg_data while the block is idle.
// Sequence
//   The block takes one action at a time; s_tready is high only while idle.
//   A deposit runs three axis scalings through the shared multiplier (S_AX then
//   S_AXST for each) and then, per mesh corner, two weight products, one mass
//   product and one read-modify-write (S_WXY, S_WXYZ, S_CONTRIB, S_ACC). A read
//   passes S_RDW, a clear writes all NODES_PER_DIM^3 nodes in S_CLR (one node
//   written per cycle) and an unused action goes straight to S_DONE.
// Reset and stall
//   After reset a clearing pass writes zero to all NODES_PER_DIM^3 nodes; s_tready
//   stays low meanwhile. The result sits in an output register; the block already
//   accepts the next action while it waits, and holds the following result until
//   m_tready.
`default_nettype none

module cic_mass_deposit_3d #(
    parameter int NODES_PER_DIM = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration: inv_cell_size, unsigned Q8.24
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [143:0] s_tdata,   // pos_x, pos_y, pos_z, particle_mass, node_index, pad
    input  wire logic [1:0]   s_tuser,   // action
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,   // node_mass
    output logic              m_tuser    // saturated
);

    localparam int IW = cmd3d_pkg::IDXW_W;
    localparam int TOTAL = NODES_PER_DIM * NODES_PER_DIM * NODES_PER_DIM;
    localparam int AW = $clog2(TOTAL);
    localparam int CW = $clog2(NODES_PER_DIM);
    localparam logic [IW-1:0] TOTAL_NODES = IW'(TOTAL);
    localparam logic [IW-1:0] LAST_NODE   = IW'(TOTAL - 1);
    localparam logic [IW-1:0] EDGE_NODE   = IW'(NODES_PER_DIM - 1);
    localparam logic [IW-1:0] ROW_STRIDE  = IW'(NODES_PER_DIM);
    localparam logic [IW-1:0] PLANE_STRIDE = IW'(NODES_PER_DIM * NODES_PER_DIM);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_AX,
        S_AXST,
        S_WXY,
        S_WXYZ,
        S_CONTRIB,
        S_ACC,
        S_CLR,
        S_RDW,
        S_DONE
    } state_t;

    // control registers
    state_t                           state_reg, state_next;
    logic [1:0]                       ax_reg, ax_next;
    logic [2:0]                       corner_reg, corner_next;
    logic [AW-1:0]                    clr_reg, clr_next;
    logic                             sat_reg, sat_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [cmd3d_pkg::ACC_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                             m_tuser_reg, m_tuser_next;
    logic [cmd3d_pkg::INV_W-1:0]      inv_reg;

    // payload registers
    cmd3d_pkg::action_t               act_reg;
    logic [cmd3d_pkg::POS_W-1:0]      pos_reg [3];
    logic [cmd3d_pkg::MASS_W-1:0]     mass_reg;
    logic                             oob_reg;
    logic [AW-1:0]                    addr_reg;
    logic [CW-1:0]                    n0_reg [3];
    logic [CW-1:0]                    n1_reg [3];
    logic [cmd3d_pkg::FRAC_W-1:0]     frac_reg [3];
    logic [cmd3d_pkg::PROD_W-1:0]     prod_reg;

    // datapath signals
    logic                             s_accept;
    logic [cmd3d_pkg::MUL_A_W-1:0]    mul_a;
    logic [cmd3d_pkg::MUL_B_W-1:0]    mul_b;
    logic [cmd3d_pkg::WGT_W-1:0]      wx, wy, wz;
    logic [CW-1:0]                    nx, ny, nz;
    logic [IW-1:0]                    corner_idx;
    logic [IW-1:0]                    rd_idx;
    logic [cmd3d_pkg::CELL_W-1:0]     axis_cell;
    logic [cmd3d_pkg::ACC_W:0]        acc_sum;
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [cmd3d_pkg::ACC_W-1:0]      ram_wdata;
    logic [cmd3d_pkg::ACC_W-1:0]      ram_rdata;

    // clamp a node coordinate to the mesh edge
    function automatic logic [CW-1:0] clamp_node(input logic [IW-1:0] c);
        logic [CW-1:0] r;
        if (c > EDGE_NODE)
        begin
            r = CW'(NODES_PER_DIM - 1);
        end
        else
        begin
            r = c[CW-1:0];
        end
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // corner weights: low corner takes 1 - frac, high corner takes frac
    assign wx = corner_reg[2] ? {1'b0, frac_reg[0]} : cmd3d_pkg::ONE_Q16 - {1'b0, frac_reg[0]};
    assign wy = corner_reg[1] ? {1'b0, frac_reg[1]} : cmd3d_pkg::ONE_Q16 - {1'b0, frac_reg[1]};
    assign wz = corner_reg[0] ? {1'b0, frac_reg[2]} : cmd3d_pkg::ONE_Q16 - {1'b0, frac_reg[2]};

    // linear node index of the current corner
    assign nx = corner_reg[2] ? n1_reg[0] : n0_reg[0];
    assign ny = corner_reg[1] ? n1_reg[1] : n0_reg[1];
    assign nz = corner_reg[0] ? n1_reg[2] : n0_reg[2];
    assign corner_idx = IW'(nx) + IW'(ny) * ROW_STRIDE + IW'(nz) * PLANE_STRIDE;

    assign rd_idx    = IW'(s_tdata[142:128]);
    assign axis_cell = prod_reg[63:40];

    // operand select of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_AX:
            begin
                mul_a = {1'b0, pos_reg[ax_reg]};
                mul_b = inv_reg;
            end
            S_WXY:
            begin
                mul_a = cmd3d_pkg::MUL_A_W'(wx);
                mul_b = cmd3d_pkg::MUL_B_W'(wy);
            end
            S_WXYZ:
            begin
                mul_a = prod_reg[32:0];
                mul_b = cmd3d_pkg::MUL_B_W'(wz);
            end
            S_CONTRIB:
            begin
                mul_a = cmd3d_pkg::MUL_A_W'(prod_reg[48:32]);
                mul_b = mass_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // accumulate with saturation
    assign acc_sum = {1'b0, ram_rdata} + (cmd3d_pkg::ACC_W + 1)'(prod_reg[47:16]);

    // mesh store write port: clearing sweep or corner update
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        if (state_reg == S_INIT || state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
        end
        else if (state_reg == S_ACC)
        begin
            ram_we    = 1'b1;
            ram_wdata = acc_sum[cmd3d_pkg::ACC_W] ? '1 : acc_sum[cmd3d_pkg::ACC_W-1:0];
        end
    end

    cmd3d_ram #(
        .WIDTH (cmd3d_pkg::ACC_W),
        .DEPTH (TOTAL)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        ax_next       = ax_reg;
        corner_next   = corner_reg;
        clr_next      = clr_reg;
        sat_next      = sat_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // result taken downstream
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg) inside
            S_INIT, S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (IW'(clr_reg) == LAST_NODE)
                begin
                    clr_next   = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE:
            begin
                if (s_accept)
                begin
                    sat_next    = 1'b0;
                    ax_next     = '0;
                    corner_next = '0;
                    clr_next    = '0;
                    case (s_tuser)
                        cmd3d_pkg::ACT_DEPOSIT: state_next = S_AX;
                        cmd3d_pkg::ACT_CLEAR:   state_next = S_CLR;
                        cmd3d_pkg::ACT_READ:    state_next = S_RDW;
                        default:                state_next = S_DONE;
                    endcase
                end
            end
            S_AX:
            begin
                state_next = S_AXST;
            end
            S_AXST:
            begin
                if (ax_reg == 2'd2)
                begin
                    state_next = S_WXY;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_AX;
                end
            end
            S_WXY:
            begin
                state_next = S_WXYZ;
            end
            S_WXYZ:
            begin
                state_next = S_CONTRIB;
            end
            S_CONTRIB:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (acc_sum[cmd3d_pkg::ACC_W])
                begin
                    sat_next = 1'b1;
                end
                corner_next = corner_reg + 3'd1;
                state_next  = (corner_reg == 3'd7) ? S_DONE : S_WXY;
            end
            S_RDW:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = sat_reg;
                    m_tdata_next  = (act_reg == cmd3d_pkg::ACT_READ && !oob_reg) ?
                                    ram_rdata : '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            ax_reg       <= '0;
            corner_reg   <= '0;
            clr_reg      <= '0;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
            inv_reg      <= cmd3d_pkg::INV_CELL_INIT;
        end
        else
        begin
            state_reg    <= state_next;
            ax_reg       <= ax_next;
            corner_reg   <= corner_next;
            clr_reg      <= clr_next;
            sat_reg      <= sat_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            if (cfg_we)
            begin
                inv_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        // capture the transaction
        if (s_accept)
        begin
            act_reg    <= cmd3d_pkg::action_t'(s_tuser);
            pos_reg[0] <= s_tdata[31:0];
            pos_reg[1] <= s_tdata[63:32];
            pos_reg[2] <= s_tdata[95:64];
            mass_reg   <= s_tdata[127:96];
            oob_reg    <= (rd_idx >= TOTAL_NODES);
            addr_reg   <= rd_idx[AW-1:0];
        end

        // cell index and fraction of one axis
        if (state_reg == S_AXST)
        begin
            n0_reg[ax_reg]   <= clamp_node(IW'(axis_cell));
            n1_reg[ax_reg]   <= clamp_node(IW'(axis_cell) + IW'(1));
            frac_reg[ax_reg] <= prod_reg[39:24];
        end

        // node address of the corner being worked on
        if (state_reg == S_WXY)
        begin
            addr_reg <= corner_idx[AW-1:0];
        end
    end

    // a transaction accepted leaves the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an action is in progress");

    // only deposits saturate, and a deposit reports zero node mass
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("saturation flag on a result carrying node mass");

    // every store write stays inside the mesh
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> IW'(ram_waddr) < TOTAL_NODES)
        else $error("mesh write beyond the last node");

    // a corner update comes in the cycle right after the mass product
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> $past(state_reg) == S_CONTRIB)
        else $error("accumulate without a fresh contribution");

endmodule

`default_nettype wire

@@ verif/cic_mass_deposit_3d_checker.sv @@
// cic_deposit_checker: watches the streams of cic_mass_deposit_3d, predicts every result
// from its own copy of the mesh and the scale register, and counts mismatches
// depends on cmd3d_pkg for the action codes and field widths

module cic_deposit_checker #(
    parameter int NODES_PER_DIM = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [143:0] s_tdata,   // pos_x, pos_y, pos_z, particle_mass, node_index, pad
    input  wire logic [1:0]   s_tuser,   // action
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [47:0]  m_tdata,   // node_mass
    input  wire logic         m_tuser,   // saturated
    output int                replies_owed,
    output int                fail_count
);

    localparam int N           = NODES_PER_DIM;
    localparam int TOTAL_NODES = N * N * N;
    localparam int ACC_W       = cmd3d_pkg::ACC_W;
    localparam int WGT_W       = cmd3d_pkg::WGT_W;
    localparam logic [ACC_W:0] ACC_MAX = {1'b0, {ACC_W{1'b1}}};

    typedef struct packed {
        logic [ACC_W-1:0] node_mass;
        logic             saturated;
    } mesh_reply_t;

    logic [ACC_W-1:0]            mesh_model [TOTAL_NODES];
    logic [cmd3d_pkg::INV_W-1:0] scale_model = cmd3d_pkg::INV_CELL_INIT;
    mesh_reply_t                 replies_due [$];
    int                          mismatches = 0;

    initial
    begin
        replies_owed = 0;
        fail_count   = 0;
    end

    // spread one particle over its 8 cloud-in-cell corners; returns the saturation flag
    function automatic logic spread_mass(input logic [31:0] px, input logic [31:0] py,
                                         input logic [31:0] pz, input logic [31:0] pm);
        logic [31:0]     axis_pos [3];
        logic [24:0]     cell_pos [3];
        logic [WGT_W-1:0] frac [3];
        logic [63:0]     grid;
        logic [WGT_W-1:0] wx, wy, wz;
        logic [63:0]     weight, share;
        logic [24:0]     nx, ny, nz;
        int unsigned     node;
        logic [ACC_W:0]  sum;
        logic            sat;
        int              a, i, j, k;
        sat = 1'b0;
        axis_pos[0] = px;
        axis_pos[1] = py;
        axis_pos[2] = pz;
        // grid coordinate in Q24.40, cell index and truncated Q0.16 fraction
        for (a = 0; a < 3; a++)
        begin
            grid        = {32'd0, axis_pos[a]} * {32'd0, scale_model};
            cell_pos[a] = {1'b0, grid[63:40]};
            frac[a]     = {1'b0, grid[39:24]};
        end
        for (i = 0; i < 2; i++)
        begin
            for (j = 0; j < 2; j++)
            begin
                for (k = 0; k < 2; k++)
                begin
                    wx = (i != 0) ? frac[0] : cmd3d_pkg::ONE_Q16 - frac[0];
                    wy = (j != 0) ? frac[1] : cmd3d_pkg::ONE_Q16 - frac[1];
                    wz = (k != 0) ? frac[2] : cmd3d_pkg::ONE_Q16 - frac[2];
                    weight = (64'(wx) * 64'(wy) * 64'(wz)) >> 32;
                    share  = (64'(pm) * weight) >> 16;
                    // corners past the mesh edge fold onto the boundary node
                    nx = cell_pos[0] + 25'(i);
                    ny = cell_pos[1] + 25'(j);
                    nz = cell_pos[2] + 25'(k);
                    if (nx > 25'(N - 1)) nx = 25'(N - 1);
                    if (ny > 25'(N - 1)) ny = 25'(N - 1);
                    if (nz > 25'(N - 1)) nz = 25'(N - 1);
                    node = int'(nx) + int'(ny) * N + int'(nz) * N * N;
                    sum  = {1'b0, mesh_model[node]} + share[ACC_W:0];
                    if (sum > ACC_MAX)
                    begin
                        mesh_model[node] = {ACC_W{1'b1}};
                        sat = 1'b1;
                    end
                    else
                    begin
                        mesh_model[node] = sum[ACC_W-1:0];
                    end
                end
            end
        end
        return sat;
    endfunction

    // track the register, predict on each input transaction, compare each output one
    always @(posedge clk or negedge rst_n)
    begin : watch
        mesh_reply_t want;
        int          n;
        if (!rst_n)
        begin
            for (n = 0; n < TOTAL_NODES; n++)
                mesh_model[n] = '0;
            scale_model = cmd3d_pkg::INV_CELL_INIT;
            replies_due.delete();
            replies_owed <= 0;
        end
        else
        begin
            if (cfg_we)
                scale_model = cfg_data;

            // output side first: a result never shares an edge with its own request
            if (m_tvalid && m_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("unexpected result transaction: node_mass %0h, saturated %0b",
                           m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (m_tdata !== want.node_mass)
                    begin
                        $error("node_mass mismatch: expected %0h, actual %0h",
                               want.node_mass, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.saturated)
                    begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, m_tuser);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                want = '0;
                case (cmd3d_pkg::action_t'(s_tuser))
                    cmd3d_pkg::ACT_DEPOSIT:
                        want.saturated = spread_mass(s_tdata[31:0], s_tdata[63:32],
                                                     s_tdata[95:64], s_tdata[127:96]);
                    cmd3d_pkg::ACT_CLEAR:
                        for (n = 0; n < TOTAL_NODES; n++)
                            mesh_model[n] = '0;
                    cmd3d_pkg::ACT_READ:
                        if (int'(s_tdata[142:128]) < TOTAL_NODES)
                            want.node_mass = mesh_model[s_tdata[142:128]];
                    default: ;
                endcase
                replies_due.push_back(want);
            end

            replies_owed <= replies_due.size();
            fail_count   <= mismatches;
        end
    end

endmodule

@@ verif/tb_top.sv @@
// tb_top: stimulus and verdict for cic_mass_deposit_3d, directed and random transactions
// over several cell-size settings, with random gaps on both streams
// depends on cmd3d_pkg, the block itself and cic_deposit_checker

module tb_top;

    localparam int N     = 32;
    localparam int LIMIT = 2_000_000;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         cfg_we   = 1'b0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata  = '0;   // pos_x, pos_y, pos_z, particle_mass, node_index, pad
    logic [1:0]   s_tuser  = '0;   // action
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;         // node_mass
    logic         m_tuser;         // saturated

    int   replies_owed;
    int   fail_count;
    int   cycles      = 0;
    int   stall_left  = 0;
    int   clears_left = 8;
    logic quiet       = 1'b0;

    always #5 clk = ~clk;

    cic_mass_deposit_3d #(
        .NODES_PER_DIM(N)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cic_deposit_checker #(
        .NODES_PER_DIM(N)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .replies_owed (replies_owed),
        .fail_count   (fail_count)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // axis position: random, near the low corner, near or past the far edge, or anywhere
    function automatic logic [31:0] aim_axis(input logic [31:0] scale);
        logic [63:0] target;
        logic [63:0] p;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom;
        if (r < 40)
            target = 64'($urandom_range(0, 3)) << 40;
        else if (r < 75)
            target = 64'($urandom_range(N - 4, N + 1)) << 40;
        else
            target = 64'($urandom_range(0, N + 8)) << 40;
        if ($urandom_range(0, 9) != 0)
            target = target | {24'd0, 8'($urandom), 32'($urandom)};
        p = target / 64'(scale);
        if (p > 64'hFFFF_FFFF)
            return $urandom;
        return p[31:0];
    endfunction

    // node coordinate in the corner regions where deposits pile up
    function automatic int edge_coord();
        if ($urandom_range(0, 1) != 0)
            return $urandom_range(0, 3);
        return $urandom_range(N - 4, N - 1);
    endfunction

    // present one input transaction after a random gap and wait for its acceptance
    task automatic send_item(input cmd3d_pkg::action_t act, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz,
                             input logic [31:0] pm, input logic [14:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, idx, pm, pz, py, px};
        do @(posedge clk); while (!s_tready);
    endtask

    // write the scale register once every result is out and the block is idle
    task automatic load_scale(input logic [31:0] value);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (replies_owed != 0);
        while (!s_tready) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // random mix: mostly deposits and reads aimed at the same regions
    task automatic random_batch(input int count, input logic [31:0] scale);
        int          n, r;
        logic [31:0] pm;
        logic [14:0] idx;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 29) == 0)
                quiet <= ~quiet;
            r = $urandom_range(0, 99);
            if (r < 10)
                pm = '0;
            else if (r < 25)
                pm = '1;
            else
                pm = $urandom;
            if ($urandom_range(0, 9) < 7)
                idx = 15'(edge_coord() + edge_coord() * N + edge_coord() * N * N);
            else
                idx = 15'($urandom);
            r = $urandom_range(0, 99);
            if (r < 2 && clears_left > 0)
            begin
                clears_left--;
                send_item(cmd3d_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, idx);
            end
            else if (r < 62)
                send_item(cmd3d_pkg::ACT_DEPOSIT, aim_axis(scale), aim_axis(scale),
                          aim_axis(scale), pm, idx);
            else if (r < 95)
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom, idx);
            else
                send_item(cmd3d_pkg::ACT_NONE, $urandom, $urandom, $urandom, pm, idx);
        end
    endtask

    // result side: random stalls, with calm stretches while quiet
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[cic_mass_deposit_3d] ERROR");
            $finish;
        end
    end

    // main sequence
    initial
    begin : stimulus
        logic [31:0] scales [7];
        int          p;
        scales[0] = cmd3d_pkg::INV_CELL_INIT;
        scales[1] = 32'd1;
        scales[2] = 32'hFFFF_FFFF;
        scales[3] = 32'h0080_0000;
        scales[4] = 32'h0400_0000;
        scales[5] = $urandom_range(32'h0020_0000, 32'h0800_0000);
        scales[6] = $urandom | 32'd1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < 7; p++)
        begin
            load_scale(scales[p]);
            if (p == 0)
            begin
                // directed: unit cell size, so a position's integer part is its cell
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom, 15'd0);
                send_item(cmd3d_pkg::ACT_NONE, '1, '1, '1, '1, '1);
                send_item(cmd3d_pkg::ACT_DEPOSIT, '0, '0, '0, '1, 15'($urandom));
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom, 15'd0);
                send_item(cmd3d_pkg::ACT_DEPOSIT, 32'h0001_8000, 32'h0002_4000,
                          32'h0003_C000, 32'h0001_0000, 15'($urandom));
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom,
                          15'(1 + 2 * N + 3 * N * N));
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom,
                          15'(2 + 3 * N + 4 * N * N));
                // edge clamping: upper corners fold onto the last node
                send_item(cmd3d_pkg::ACT_DEPOSIT, 32'h001F_8000, 32'h001F_8000,
                          32'h001F_8000, '1, 15'($urandom));
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom,
                          15'(N * N * N - 1));
                send_item(cmd3d_pkg::ACT_DEPOSIT, '1, '1, '1, '1, 15'($urandom));
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom,
                          15'(N * N * N - 1));
                send_item(cmd3d_pkg::ACT_DEPOSIT, 32'h001F_FFFF, '0, '0, 32'h1234_5678,
                          15'($urandom));
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom,
                          15'(N - 1));
                send_item(cmd3d_pkg::ACT_DEPOSIT, 32'h0000_4000, 32'h0001_C000,
                          32'h0000_0001, '0, 15'($urandom));
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom,
                          15'(N));
                // clear, then the mesh must read back empty
                send_item(cmd3d_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom,
                          15'($urandom));
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom,
                          15'(N * N * N - 1));
                send_item(cmd3d_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom, 15'd0);
                send_item(cmd3d_pkg::ACT_DEPOSIT, '0, '0, '0, '0, '0);
                send_item(cmd3d_pkg::ACT_NONE, '0, '0, '0, '0, '0);
            end
            random_batch(86, scales[p]);
        end

        // drain, then allow the deposit latency for anything stray
        s_tvalid <= 1'b0;
        do @(posedge clk); while (replies_owed != 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("[cic_mass_deposit_3d] OK");
        else
            $display("[cic_mass_deposit_3d] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/cmd3d_pkg.sv
rtl/cmd3d_ram.sv
rtl/cic_mass_deposit_3d.sv
verif/cic_mass_deposit_3d_checker.sv
verif/tb_top.sv
